// ===== rtl/core/linear_probe_hash_table_top_assert.svh =====
// Assertion macros shared by the hash table RTL files
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHT_ASSERT(lbl, prop, msg)
`define LPHT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/lpht_pkg.sv =====
// Types and constants of the linear probing hash table
package lpht_pkg;

  localparam int unsigned IN_DW  = 208;
  localparam int unsigned OUT_DW = 16;
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 4;
  localparam int unsigned LGW    = 5;
  localparam int unsigned MIN_LG = 3;

  localparam logic [3:0] CAP_LG_RST = 4'd10;

  localparam logic [63:0] FIB_MULT = 64'h9E3779B97F4A7C15;
  localparam logic [31:0] FIB_LO   = FIB_MULT[31:0];
  localparam logic [31:0] FIB_HI   = FIB_MULT[63:32];

  localparam logic [1:0] REQ_FIND   = 2'd0;
  localparam logic [1:0] REQ_PUT    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_CAP_LG     = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_HOLDS_VAL  = 1'd1;

  typedef struct packed {
    logic        occ;
    logic [63:0] hash;
  } meta_t;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] key;
  } data_t;

endpackage

// ===== rtl/core/lpht_ram.sv =====
// Generic simple dual-port RAM with registered read
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lpht_home.sv =====
// Fibonacci hashing unit: split 64-bit product; partial products, then their sum, are registered before the home slot
module lpht_home import lpht_pkg::*; #(
  parameter int AW = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [63:0]    hash,
  input  logic [LGW-1:0] lg,
  output logic           done,
  output logic [AW-1:0]  home
);

  logic        v1_r, v2_r;
  logic [63:0] p_lo_r, p_lo_nxt;
  logic [31:0] p_x1_r, p_x1_nxt;
  logic [31:0] p_x2_r, p_x2_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [6:0]  shamt;
  logic [63:0] shifted;

  assign p_lo_nxt = hash[31:0] * FIB_LO;
  assign p_x1_nxt = hash[31:0] * FIB_HI;
  assign p_x2_nxt = hash[63:32] * FIB_LO;
  assign sum_nxt  = p_lo_r + {p_x1_r + p_x2_r, 32'h0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_lo_r <= p_lo_nxt;
    p_x1_r <= p_x1_nxt;
    p_x2_r <= p_x2_nxt;
    sum_r  <= sum_nxt;
  end

  assign shamt   = 7'd64 - 7'(lg);
  assign shifted = sum_r >> shamt;
  assign home    = AW'(shifted);
  assign done    = v2_r;

`include "linear_probe_hash_table_top_assert.svh"

  `LPHT_ASSERT(a_home_latency, start |-> ##2 done, "home slot not ready two cycles after start")

endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// Linear probing hash table with backward shift delete, top level
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tuser req_type, tdata key value hash slot_index
//  out_    | out | out_tvalid/out_tready | tdata result_slot status
//  cfg_    | in  | cfg_wr_en           | cfg_addr register, cfg_wdata value
//
// Find free: hashes the home slot, then probes one slot per metadata RAM read.
// Put: writes the entry directly when values are held, else a read-merge of the stored value word.
// Remove: per occupied slot walked, a read and the two-stage home hash; the read is issued
// from a separate state when it would hit the entry written that cycle.
// After reset a clearing pass empties all MAX_SLOTS metadata entries; no beat is taken then.
// A result waits in the output register; the next one holds the block in its done state
// until out_tready drains the register.
module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // key[63:0], value[127:64], hash[191:128], slot_index[201:192]
  input  logic [1:0]        in_tuser,   // req_type[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // result_slot[9:0], status[10]
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW     = $clog2(MAX_SLOTS);
  localparam int MAX_LG = $clog2(MAX_SLOTS + 1) - 1;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FHASH = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_PUTWR = 4'd4;
  localparam logic [3:0] S_RISS  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_RCLR  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    cap_lg_r;
  logic          holds_val_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] hole_r, hole_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          status_r, status_nxt;
  logic [63:0]   key_r, key_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [9:0]    out_slot_r;
  logic          out_status_r;
  logic          out_load;

  logic [1:0]    in_req;
  logic [63:0]   in_key, in_value, in_hash;
  logic [9:0]    in_slot_idx;

  logic [3:0]     lg_clamp;
  logic [LGW-1:0] lg;
  logic [AW:0]    cap;
  logic [AW-1:0]  mask;
  logic [AW-1:0]  in_slot, in_slot_next, j_inc, hole_new;
  logic           stays;

  logic           meta_we, meta_re, data_we, data_re;
  logic [AW-1:0]  meta_waddr, data_waddr, raddr;
  meta_t          meta_wdata, meta_rd;
  data_t          data_wdata, data_rd;

  logic           hu_start, hu_done;
  logic [63:0]    hu_hash;
  logic [AW-1:0]  hu_home;

  assign in_req      = in_tuser;
  assign in_key      = in_tdata[63:0];
  assign in_value    = in_tdata[127:64];
  assign in_hash     = in_tdata[191:128];
  assign in_slot_idx = in_tdata[201:192];

  assign lg_clamp = (cap_lg_r < 4'(MIN_LG)) ? 4'(MIN_LG) : cap_lg_r;
  assign lg       = (LGW'(lg_clamp) > LGW'(MAX_LG)) ? LGW'(MAX_LG) : LGW'(lg_clamp);
  assign cap      = (AW + 1)'(1) << lg;
  assign mask     = AW'(cap - 1'b1);

  assign in_slot      = AW'(in_slot_idx) & mask;
  assign in_slot_next = (in_slot + 1'b1) & mask;
  assign j_inc        = (j_r + 1'b1) & mask;

  assign stays = (hole_r <= j_r) ? ((hole_r < hu_home) && (hu_home <= j_r))
                                 : ((hole_r < hu_home) || (hu_home <= j_r));
  assign hole_new = stays ? hole_r : j_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    j_nxt        = j_r;
    hole_nxt     = hole_r;
    cnt_nxt      = cnt_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    key_nxt      = key_r;
    meta_we      = 1'b0;
    meta_waddr   = hole_r;
    meta_wdata   = '0;
    data_we      = 1'b0;
    data_waddr   = hole_r;
    data_wdata   = data_rd;
    meta_re      = 1'b0;
    data_re      = 1'b0;
    raddr        = j_r;
    hu_start     = 1'b0;
    hu_hash      = meta_rd.hash;
    unique case (state_r)
      S_CLR: begin
        meta_we      = 1'b1;
        meta_waddr   = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          slot_nxt   = in_slot;
          status_nxt = 1'b0;
          key_nxt    = in_key;
          unique case (in_req)
            REQ_FIND: begin
              hu_start  = 1'b1;
              hu_hash   = in_hash;
              state_nxt = S_FHASH;
            end
            REQ_PUT: begin
              meta_we    = 1'b1;
              meta_waddr = in_slot;
              meta_wdata = '{occ: 1'b1, hash: in_hash};
              if (holds_val_r) begin
                data_we    = 1'b1;
                data_waddr = in_slot;
                data_wdata = '{value: in_value, key: in_key};
                state_nxt  = S_DONE;
              end else begin
                data_re   = 1'b1;
                raddr     = in_slot;
                state_nxt = S_PUTWR;
              end
            end
            REQ_REMOVE: begin
              hole_nxt  = in_slot;
              j_nxt     = in_slot_next;
              state_nxt = (in_slot_next == in_slot) ? S_RCLR : S_RISS;
            end
            REQ_NOP: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FHASH: begin
        if (hu_done) begin
          j_nxt     = hu_home;
          cnt_nxt   = '0;
          meta_re   = 1'b1;
          raddr     = hu_home;
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        if (!meta_rd.occ) begin
          slot_nxt   = j_r;
          status_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else if ((AW + 1)'(cnt_r + 1'b1) == cap) begin
          slot_nxt   = '0;
          status_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          j_nxt   = j_inc;
          cnt_nxt = cnt_r + 1'b1;
          meta_re = 1'b1;
          raddr   = j_inc;
        end
      end
      S_PUTWR: begin
        data_we    = 1'b1;
        data_waddr = slot_r;
        data_wdata = '{value: data_rd.value, key: key_r};
        state_nxt  = S_DONE;
      end
      S_RISS: begin
        meta_re   = 1'b1;
        data_re   = 1'b1;
        state_nxt = S_RRD;
      end
      S_RRD: begin
        if (!meta_rd.occ) begin
          state_nxt = S_RCLR;
        end else begin
          hu_start  = 1'b1;
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (hu_done) begin
          if (!stays) begin
            meta_we    = 1'b1;
            meta_wdata = meta_rd;
            data_we    = 1'b1;
          end
          hole_nxt = hole_new;
          j_nxt    = j_inc;
          if (j_inc == hole_new) begin
            state_nxt = S_RCLR;
          end else if (!stays && (j_inc == hole_r)) begin
            state_nxt = S_RISS;
          end else begin
            meta_re   = 1'b1;
            data_re   = 1'b1;
            raddr     = j_inc;
            state_nxt = S_RRD;
          end
        end
      end
      S_RCLR: begin
        meta_we   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
      cap_lg_r     <= CAP_LG_RST;
      holds_val_r  <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_CAP_LG:    cap_lg_r    <= cfg_wdata[3:0];
          CFG_HOLDS_VAL: holds_val_r <= cfg_wdata[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    hole_r   <= hole_nxt;
    cnt_r    <= cnt_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    key_r    <= key_nxt;
    if (out_load) begin
      out_slot_r   <= 10'(slot_r);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_status_r, out_slot_r};

  lpht_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (MAX_SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (raddr),
    .rdata (meta_rd)
  );

  lpht_ram #(
    .WIDTH ($bits(data_t)),
    .DEPTH (MAX_SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (data_re),
    .raddr (raddr),
    .rdata (data_rd)
  );

  lpht_home #(
    .AW (AW)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hu_start),
    .hash  (hu_hash),
    .lg    (lg),
    .done  (hu_done),
    .home  (hu_home)
  );

`include "linear_probe_hash_table_top_assert.svh"

  `LPHT_ASSERT(a_no_rw_collide, (meta_we && meta_re) |-> (meta_waddr != raddr), "metadata read hits the entry written in the same cycle")
  `LPHT_ASSERT(a_walk_not_hole, (state_r == S_RRD) |-> (j_r != hole_r), "remove walk reached its own hole")
  `LPHT_ASSERT(a_probe_bound, (state_r == S_FRD) |-> (cnt_r < cap), "find free probed past the capacity")
  `LPHT_ASSERT(a_full_slot_zero, ((state_r == S_DONE) && status_r) |-> (slot_r == '0), "full status with nonzero slot")
  `LPHT_ASSERT(a_slot_in_range, (state_r == S_DONE) |-> ((slot_r & ~mask) == '0), "result slot beyond capacity")
  `LPHT_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_tvalid && !in_tready), "channels active right after reset")

endmodule

// ===== verif/linear_probe_hash_table_top_tb.sv =====
// Stream testbench of the linear probing hash table: predicted slot and status per request beat
module linear_probe_hash_table_top_tb import lpht_pkg::*; ();

  localparam int unsigned TBL_SLOTS   = 1024;
  localparam int unsigned TBL_LG      = 10;
  localparam int unsigned PLAN        = 0;
  localparam int unsigned MODEL       = 1;
  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam logic [23:0] PHASE_CAP   = {4'd6, 4'd10, 4'd1, 4'd15, 4'd3, 4'd5};
  localparam logic [5:0]  PHASE_HOLDS = 6'b010101;

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
    logic [9:0]  slot;
  } table_req_t;

  typedef struct packed {
    logic       status;
    logic [9:0] slot;
  } table_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;   // key[63:0], value[127:64], hash[191:128], slot_index[201:192]
  logic [1:0]        in_tuser = '0;   // req_type[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;       // result_slot[9:0], status[10]
  logic              cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  bit          slot_live [2][TBL_SLOTS];
  logic [63:0] slot_hash [2][TBL_SLOTS];
  logic [3:0]  cap_lg_reg = CAP_LG_RST;
  logic [63:0] hash_pool [8];

  table_req_t  pending_reqs [$];
  table_resp_t pending_results [$];
  table_req_t  drive_req;
  table_req_t  seen_req;
  table_resp_t next_result;
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 80;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned issued_count = 0;
  int unsigned result_count = 0;

  linear_probe_hash_table_top #(.MAX_SLOTS(TBL_SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int unsigned used_lg();
    int unsigned lg;
    lg = cap_lg_reg;
    if (lg < MIN_LG) lg = MIN_LG;
    if (lg > TBL_LG) lg = TBL_LG;
    return lg;
  endfunction

  function automatic int unsigned home_slot(logic [63:0] hash, int unsigned lg);
    logic [63:0] prod;
    prod = hash * FIB_MULT;
    return int'(prod >> (64 - lg));
  endfunction

  function automatic table_resp_t table_step(int unsigned c, table_req_t r);
    int unsigned lg, cap, mask, slot, hole, j, n, h;
    logic        stays;
    table_resp_t resp;
    lg = used_lg();
    cap = 1 << lg;
    mask = cap - 1;
    slot = r.slot & mask;
    resp.slot = slot[9:0];
    resp.status = 1'b0;
    case (r.req)
      REQ_FIND: begin
        resp.slot = '0;
        resp.status = 1'b1;
        j = home_slot(r.hash, lg);
        for (n = 0; n < cap; n++) begin
          if (!slot_live[c][j]) begin
            resp.slot = j[9:0];
            resp.status = 1'b0;
            break;
          end
          j = (j + 1) & mask;
        end
      end
      REQ_PUT: begin
        slot_hash[c][slot] = r.hash;
        slot_live[c][slot] = 1'b1;
      end
      REQ_REMOVE: begin
        hole = slot;
        for (j = (slot + 1) & mask; j != hole; j = (j + 1) & mask) begin
          if (!slot_live[c][j]) break;
          h = home_slot(slot_hash[c][j], lg);
          stays = (hole <= j) ? (hole < h && h <= j) : (hole < h || h <= j);
          if (!stays) begin
            slot_live[c][hole] = slot_live[c][j];
            slot_hash[c][hole] = slot_hash[c][j];
            hole = j;
          end
        end
        slot_live[c][hole] = 1'b0;
      end
      default: ;
    endcase
    return resp;
  endfunction

  function automatic int unsigned count_live(int unsigned c, int unsigned cap);
    int unsigned live;
    live = 0;
    for (int unsigned i = 0; i < cap; i++) live += slot_live[c][i];
    return live;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_hash();
    return ($urandom_range(1) == 1) ? hash_pool[$urandom_range(7)] : rand64();
  endfunction

  function automatic table_req_t mk_req(logic [1:0] req, logic [63:0] hash, logic [9:0] slot);
    table_req_t r;
    r.req = req;
    r.key = rand64();
    r.value = rand64();
    r.hash = hash;
    r.slot = slot;
    return r;
  endfunction

  function automatic table_resp_t issue_request(table_req_t r);
    pending_reqs.push_back(r);
    issued_count++;
    return table_step(PLAN, r);
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (result_count < issued_count);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_CAP_LG) cap_lg_reg = val;
  endtask

  task automatic run_random_phase(int unsigned n_items);
    int unsigned made, cap, mask, live, ins_pct, pick;
    table_req_t  r;
    table_resp_t found;
    cap = 1 << used_lg();
    mask = cap - 1;
    made = 0;
    for (int i = 0; i < 8; i++) hash_pool[i] = rand64();
    hash_pool[0] = '0;
    hash_pool[1] = '1;
    while (made < n_items) begin
      live = count_live(PLAN, cap);
      ins_pct = (live * 8 > cap * 7) ? 25 : 50;
      pick = $urandom_range(99);
      r = mk_req(REQ_NOP, rand64(), 10'($urandom));
      if (pick < ins_pct) begin
        r.req = REQ_FIND;
        r.hash = pool_hash();
        found = issue_request(r);
        made++;
        if (!found.status) begin
          r.req = REQ_PUT;
          r.slot = ($urandom_range(3) == 0) ? (found.slot | (10'($urandom) & ~10'(mask)))
                                            : found.slot;
          void'(issue_request(r));
          made++;
        end
      end else if (pick < 85) begin
        r.req = REQ_REMOVE;
        if (pick < 77 && live != 0) begin
          while (!slot_live[PLAN][r.slot & mask]) r.slot = 10'($urandom);
        end
        void'(issue_request(r));
        made++;
      end else if (pick < 95) begin
        r.req = REQ_PUT;
        r.hash = pool_hash();
        void'(issue_request(r));
        made++;
      end else begin
        void'(issue_request(r));
        made++;
      end
    end
  endtask

  // hold the beat until taken, then load the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drive_req.req;
        in_tdata  <= {{(IN_DW - 202){1'b0}}, drive_req.slot, drive_req.hash,
                      drive_req.value, drive_req.key};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_req.req   = in_tuser;
        seen_req.key   = in_tdata[63:0];
        seen_req.value = in_tdata[127:64];
        seen_req.hash  = in_tdata[191:128];
        seen_req.slot  = in_tdata[201:192];
        pending_results.push_back(table_step(MODEL, seen_req));
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with no request outstanding: expected none, got slot %0d status %0b",
                   $time, out_tdata[9:0], out_tdata[10]);
          mismatch_count++;
        end else begin
          next_result = pending_results.pop_front();
          if (out_tdata[9:0] !== next_result.slot) begin
            $display("%0t: result_slot mismatch: expected %0d, got %0d",
                     $time, next_result.slot, out_tdata[9:0]);
            mismatch_count++;
          end
          if (out_tdata[10] !== next_result.status) begin
            $display("%0t: status mismatch: expected %0b, got %0b",
                     $time, next_result.status, out_tdata[10]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    table_resp_t found;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    write_cfg(CFG_CAP_LG, 4'd0);
    write_cfg(CFG_HOLDS_VAL, 4'b1110);
    void'(issue_request(mk_req(REQ_FIND, '0, '0)));
    void'(issue_request('{REQ_PUT, '1, '1, 64'd0, 10'd0}));
    void'(issue_request(mk_req(REQ_FIND, '0, 10'h3FF)));
    void'(issue_request('{REQ_PUT, '0, '0, 64'd0, 10'h3F9}));
    void'(issue_request(mk_req(REQ_PUT, 64'h8000_0000_0000_0000, 10'h002)));
    void'(issue_request(mk_req(REQ_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 10'h3FB)));
    void'(issue_request(mk_req(REQ_PUT, '1, 10'h004)));
    void'(issue_request(mk_req(REQ_PUT, rand64(), 10'h105)));
    void'(issue_request(mk_req(REQ_PUT, rand64(), 10'h006)));
    void'(issue_request(mk_req(REQ_PUT, rand64(), 10'h207)));
    void'(issue_request(mk_req(REQ_FIND, rand64(), '0)));
    void'(issue_request(mk_req(REQ_NOP, '1, 10'h3FF)));
    void'(issue_request(mk_req(REQ_REMOVE, rand64(), 10'h000)));
    void'(issue_request(mk_req(REQ_REMOVE, rand64(), 10'h000)));
    void'(issue_request(mk_req(REQ_REMOVE, rand64(), 10'h3FB)));
    void'(issue_request(mk_req(REQ_FIND, '0, '0)));
    found = issue_request(mk_req(REQ_FIND, '1, '0));
    void'(issue_request(mk_req(REQ_PUT, '1, found.slot)));
    void'(issue_request(mk_req(REQ_FIND, 64'h7FFF_FFFF_FFFF_FFFF, '0)));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 2) begin
        send_idle_pct = 80;
        recv_idle_pct = 12;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_cfg(CFG_CAP_LG, PHASE_CAP[ph*4 +: 4]);
      write_cfg(CFG_HOLDS_VAL, {3'($urandom), PHASE_HOLDS[ph]});
      run_random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_home.sv
rtl/core/linear_probe_hash_table_top.sv
verif/linear_probe_hash_table_top_tb.sv
